// ===== design/fire_pkg.sv =====
`default_nettype none

package fire_pkg;

    localparam int WIDTH  = 320;
    localparam int HEIGHT = 240;
    localparam int DEPTH  = WIDTH * HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);

    localparam int COL_W = 9;
    localparam int ROW_W = 8;
    localparam int PIX_W = 8;

    localparam logic [PIX_W-1:0] HOT_RESET  = 8'd192;
    localparam logic [PIX_W-1:0] COLD_RESET = 8'd32;

    // floor(n / 3) as (n * 683) >> 11, exact for n below 2048
    localparam int THIRD_MUL = 683;
    localparam int THIRD_SH  = 11;

    localparam logic [1:0] OP_SEED   = 2'd0;
    localparam logic [1:0] OP_UPDATE = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;

    localparam logic CFG_HOT_LEVEL  = 1'b0;
    localparam logic CFG_COLD_LEVEL = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SEED_L,
        ST_SEED_R,
        ST_UPD_C,
        ST_UPD_R,
        ST_UPD_W,
        ST_RD_W
    } state_t;

endpackage

`default_nettype wire

// ===== design/fire_in_if.sv =====
`default_nettype none

interface fire_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic       hot;
    logic [8:0] col;
    logic [7:0] row;

    modport source (output valid, output op, output hot, output col, output row,
                    input ready);
    modport sink   (input valid, input op, input hot, input col, input row,
                    output ready);
endinterface

`default_nettype wire

// ===== design/fire_out_if.sv =====
`default_nettype none

interface fire_out_if;
    logic       valid;
    logic       ready;
    logic [8:0] out_col;
    logic [7:0] out_row;
    logic [7:0] pixel;
    logic       frame_done;

    modport source (output valid, output out_col, output out_row, output pixel,
                    output frame_done, input ready);
    modport sink   (input valid, input out_col, input out_row, input pixel,
                    input frame_done, output ready);
endinterface

`default_nettype wire

// ===== design/fire_ram.sv =====
`default_nettype none

module fire_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [DATA_W-1:0]        wdata,
    output logic      [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== design/fire_effect_frame_update.sv =====
// channel  dir  fields                              word
// cmd      in   op, hot, col, row                   one operation
// res      out  out_col, out_row, pixel, frame_done one reported pixel
// cfg      in   cfg_we, cfg_index, cfg_data         level register write
//
// seed writes one pixel cold, three pixels hot (one frame memory write port)
// update does three reads and a write on smoothed rows, one read and a write near the bottom
// read does one frame memory read; all operations share one single-port frame memory
// after reset a clearing pass zeroes all 76800 pixels with cmd.ready low
// a result waits in the output register; the next word is taken meanwhile,
// and only an update or read that finishes into a full output register stalls
`default_nettype none

module fire_effect_frame_update (
    input  wire logic       clk,
    input  wire logic       rst_n,
    fire_in_if.sink         cmd,
    fire_out_if.source      res,
    input  wire logic       cfg_we,
    input  wire logic       cfg_index,
    input  wire logic [7:0] cfg_data
);
    import fire_pkg::*;

    state_t state_reg, state_next;

    logic [ADDR_W-1:0] clr_cnt_reg;
    logic [PIX_W-1:0]  hot_level_reg, cold_level_reg;
    logic [COL_W-1:0]  seed_col_reg, upd_col_reg, rd_col_reg;
    logic [ROW_W-1:0]  upd_row_reg, rd_row_reg;
    logic              smooth_reg, rd_ok_reg;
    logic [PIX_W-1:0]  left_reg, center_reg;

    logic              out_valid_reg, out_done_reg;
    logic [COL_W-1:0]  out_col_reg;
    logic [ROW_W-1:0]  out_row_reg;
    logic [PIX_W-1:0]  out_pixel_reg;

    logic              accept, slot_free, out_load, last_col, last_row;
    logic              smooth_now, rd_in_range;
    logic              ram_we, ram_re;
    logic [ADDR_W-1:0] ram_addr;
    logic [PIX_W-1:0]  ram_wdata, ram_rdata;
    logic [ROW_W-1:0]  row_sel;
    logic [COL_W-1:0]  col_sel;
    logic [19:0]       side_prod;
    logic [PIX_W-1:0]  side_level;
    logic [9:0]        sum;
    logic [PIX_W-1:0]  src, new_pix, res_pix;

    fire_ram #(
        .DATA_W (PIX_W),
        .DEPTH  (DEPTH)
    ) u_frame (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign accept      = cmd.valid && cmd.ready;
    assign slot_free   = !out_valid_reg || res.ready;
    assign last_col    = upd_col_reg == COL_W'(WIDTH - 2);
    assign last_row    = upd_row_reg == ROW_W'(HEIGHT - 2);
    assign smooth_now  = upd_row_reg <= ROW_W'(HEIGHT - 5);
    assign rd_in_range = (cmd.col < COL_W'(WIDTH)) && (cmd.row < ROW_W'(HEIGHT));

    assign side_prod  = {11'd0, hot_level_reg, 1'b0} * 20'(THIRD_MUL);
    assign side_level = side_prod[THIRD_SH +: PIX_W];

    assign sum     = {2'b00, left_reg} + {1'b0, center_reg, 1'b0} + {2'b00, ram_rdata};
    assign src     = smooth_reg ? sum[9:2] : ram_rdata;
    assign new_pix = (src == '0) ? '0 : src - PIX_W'(1);
    assign res_pix = (state_reg == ST_UPD_W) ? new_pix : (rd_ok_reg ? ram_rdata : '0);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    priority if (cmd.op == OP_SEED && cmd.hot)
                        state_next = ST_SEED_L;
                    else if (cmd.op == OP_UPDATE && smooth_now)
                        state_next = ST_UPD_C;
                    else if (cmd.op == OP_UPDATE)
                        state_next = ST_UPD_W;
                    else if (cmd.op == OP_READ)
                        state_next = ST_RD_W;
                    else
                        state_next = ST_IDLE;
                end
            end
            ST_SEED_L: state_next = ST_SEED_R;
            ST_SEED_R: state_next = ST_IDLE;
            ST_UPD_C:  state_next = ST_UPD_R;
            ST_UPD_R:  state_next = ST_UPD_W;
            ST_UPD_W, ST_RD_W:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // memory port and handshake
    always_comb
    begin
        cmd.ready = 1'b0;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_wdata = '0;
        row_sel   = '0;
        col_sel   = '0;
        out_load  = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we = 1'b1;
            end
            ST_IDLE:
            begin
                cmd.ready = 1'b1;
                if (cmd.valid)
                begin
                    unique case (cmd.op)
                        OP_SEED:
                        begin
                            ram_we    = 1'b1;
                            ram_wdata = cmd.hot ? hot_level_reg : cold_level_reg;
                            row_sel   = ROW_W'(HEIGHT - 1);
                            col_sel   = seed_col_reg;
                        end
                        OP_UPDATE:
                        begin
                            ram_re  = 1'b1;
                            row_sel = smooth_now ? upd_row_reg + ROW_W'(2)
                                                 : upd_row_reg + ROW_W'(1);
                            col_sel = smooth_now ? upd_col_reg - COL_W'(1) : upd_col_reg;
                        end
                        OP_READ:
                        begin
                            ram_re  = rd_in_range;
                            row_sel = cmd.row;
                            col_sel = cmd.col;
                        end
                        default:
                        begin
                            ram_re = 1'b0;
                        end
                    endcase
                end
            end
            ST_SEED_L:
            begin
                ram_we    = 1'b1;
                ram_wdata = side_level;
                row_sel   = ROW_W'(HEIGHT - 1);
                col_sel   = seed_col_reg - COL_W'(1);
            end
            ST_SEED_R:
            begin
                ram_we    = 1'b1;
                ram_wdata = side_level;
                row_sel   = ROW_W'(HEIGHT - 1);
                col_sel   = seed_col_reg + COL_W'(1);
            end
            ST_UPD_C:
            begin
                ram_re  = 1'b1;
                row_sel = upd_row_reg + ROW_W'(3);
                col_sel = upd_col_reg;
            end
            ST_UPD_R:
            begin
                ram_re  = 1'b1;
                row_sel = upd_row_reg + ROW_W'(2);
                col_sel = upd_col_reg + COL_W'(1);
            end
            ST_UPD_W:
            begin
                ram_we    = slot_free;
                ram_wdata = new_pix;
                row_sel   = upd_row_reg;
                col_sel   = upd_col_reg;
                out_load  = slot_free;
            end
            ST_RD_W:
            begin
                out_load = slot_free;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
        ram_addr = (state_reg == ST_CLEAR) ? clr_cnt_reg
                 : ADDR_W'(row_sel) * ADDR_W'(WIDTH) + ADDR_W'(col_sel);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_cnt_reg    <= '0;
            hot_level_reg  <= HOT_RESET;
            cold_level_reg <= COLD_RESET;
            seed_col_reg   <= COL_W'(1);
            upd_col_reg    <= COL_W'(1);
            upd_row_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_HOT_LEVEL:  hot_level_reg  <= cfg_data;
                    CFG_COLD_LEVEL: cold_level_reg <= cfg_data;
                    default:        hot_level_reg  <= hot_level_reg;
                endcase
            end
            // seed column advances once all of its writes are issued
            if ((accept && cmd.op == OP_SEED && !cmd.hot) || state_reg == ST_SEED_R)
            begin
                seed_col_reg <= (seed_col_reg >= COL_W'(WIDTH - 2))
                              ? COL_W'(1) : seed_col_reg + COL_W'(1);
            end
            if (state_reg == ST_UPD_W && slot_free)
            begin
                if (last_col)
                begin
                    upd_col_reg <= COL_W'(1);
                    upd_row_reg <= last_row ? '0 : upd_row_reg + ROW_W'(1);
                end
                else
                begin
                    upd_col_reg <= upd_col_reg + COL_W'(1);
                end
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            smooth_reg <= smooth_now;
            rd_col_reg <= cmd.col;
            rd_row_reg <= cmd.row;
            rd_ok_reg  <= rd_in_range;
        end
        if (state_reg == ST_UPD_C)
        begin
            left_reg <= ram_rdata;
        end
        if (state_reg == ST_UPD_R)
        begin
            center_reg <= ram_rdata;
        end
        if (out_load)
        begin
            out_col_reg   <= (state_reg == ST_UPD_W) ? upd_col_reg : rd_col_reg;
            out_row_reg   <= (state_reg == ST_UPD_W) ? upd_row_reg : rd_row_reg;
            out_pixel_reg <= res_pix;
            out_done_reg  <= (state_reg == ST_UPD_W) && last_col && last_row;
        end
    end

    assign res.valid      = out_valid_reg;
    assign res.out_col    = out_col_reg;
    assign res.out_row    = out_row_reg;
    assign res.pixel      = out_pixel_reg;
    assign res.frame_done = out_done_reg;

    a_no_write_on_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RD_W) |-> !ram_we)
        else $error("frame write during read completion");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_UPD_W || $past(state_reg) == ST_RD_W))
        else $error("result appeared without a finishing update or read");

    a_upd_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        (upd_col_reg >= COL_W'(1)) && (upd_col_reg <= COL_W'(WIDTH - 2)))
        else $error("update column out of range");

    a_done_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_done_reg) |->
        (out_col_reg == COL_W'(WIDTH - 2) && out_row_reg == ROW_W'(HEIGHT - 2)))
        else $error("frame_done away from last pixel");

endmodule

`default_nettype wire
